// ----- sv/u8dec_pkg.sv -----
// shared types and constants for the utf-8 byte stream decoder
// no dependencies; imported by utf8_byte_stream_decoder_top
package u8dec_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned CP_PAD  = 24;
    localparam int unsigned REM_W   = 2;
    localparam int unsigned STAT_W  = 2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_END     = 2'd2
    } status_t;

    typedef logic [CP_W-1:0]  cp_t;
    typedef logic [REM_W-1:0] rem_t;

endpackage

// ----- sv/utf8_byte_stream_decoder_top.sv -----
// lenient utf-8 decoder: bytes in on a stream slave port, code points out on a master port
// depends on u8dec_pkg
//
// One byte is accepted per clock while the result port does not stall, and each byte is
// fully handled in a single pass between the input register and the result register,
// so a stream of bytes runs at one item per cycle until a held result blocks the input.
// Leads 0xc0-0xdf, 0xe0-0xef and 0xf0-0xff open sequences of one, two and three
// continuation bytes; continuation bytes are not checked and only their low six bits
// are used. A stray continuation byte as lead gives status invalid, an end-of-input
// flag between characters gives status end, and an end flag inside a sequence counts
// as a continuation payload of all ones. Only the final byte of a sequence produces
// a result; other bytes of a sequence produce none.
module utf8_byte_stream_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_axis_tuser,   // [0] end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import u8dec_pkg::*;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_eoi_reg;

    // decoder state
    rem_t bytes_rem_reg, bytes_rem_next;
    cp_t  partial_reg, partial_next;

    // result register
    logic    out_valid_reg;
    cp_t     out_cp_reg;
    status_t out_status_reg;

    logic    has_result;
    cp_t     res_cp;
    status_t res_status;
    logic    out_free;
    logic    fire;

    logic [5:0]  payload;
    cp_t         merged;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && (!has_result || out_free);
    assign s_axis_tready = !in_valid_reg || fire;

    always_comb begin
        payload = in_eoi_reg ? 6'h3f : in_byte_reg[5:0];
        // first continuation byte lands highest
        case (bytes_rem_reg)
            2'd3:    merged = partial_reg | {3'd0, payload, 12'd0};
            2'd2:    merged = partial_reg | {9'd0, payload, 6'd0};
            default: merged = partial_reg | {15'd0, payload};
        endcase

        bytes_rem_next = bytes_rem_reg;
        partial_next   = partial_reg;
        has_result     = 1'b0;
        res_cp         = '0;
        res_status     = ST_OK;

        if (bytes_rem_reg == '0) begin
            if (in_eoi_reg) begin
                has_result = 1'b1;
                res_status = ST_END;
            end else if (!in_byte_reg[7]) begin
                has_result = 1'b1;
                res_cp     = {13'd0, in_byte_reg};
            end else if (in_byte_reg[7:4] == 4'hf) begin
                partial_next   = {in_byte_reg[2:0], 18'd0};
                bytes_rem_next = 2'd3;
            end else if (in_byte_reg[7:5] == 3'h7) begin
                partial_next   = {1'b0, in_byte_reg[3:0], 16'd0} >> 4;
                bytes_rem_next = 2'd2;
            end else if (in_byte_reg[7:6] == 2'h3) begin
                partial_next   = {10'd0, in_byte_reg[4:0], 6'd0};
                bytes_rem_next = 2'd1;
            end else begin
                has_result = 1'b1;
                res_status = ST_INVALID;
            end
        end else begin
            bytes_rem_next = bytes_rem_reg - 2'd1;
            if (bytes_rem_reg == 2'd1) begin
                has_result   = 1'b1;
                res_cp       = merged;
                partial_next = '0;
            end else begin
                partial_next = merged;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            bytes_rem_reg <= '0;
            partial_reg   <= '0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (fire) begin
                bytes_rem_reg <= bytes_rem_next;
                partial_reg   <= partial_next;
            end
            if (fire && has_result) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
            in_eoi_reg  <= s_axis_tuser[0];
        end
        if (fire && has_result) begin
            out_cp_reg     <= res_cp;
            out_status_reg <= res_status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(CP_PAD-CP_W){1'b0}}, out_cp_reg};
    assign m_axis_tuser  = out_status_reg;

    // no partial bits linger once a sequence is closed
    a_partial_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (bytes_rem_reg == '0) |-> (partial_reg == '0))
        else $error("partial value nonzero with no sequence open");

    // only decoded characters carry a code point
    a_cp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("code point nonzero on a status result");

    // end flag between characters yields an end result next cycle
    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_eoi_reg && bytes_rem_reg == '0)
            |=> (m_axis_tvalid && m_axis_tuser == ST_END))
        else $error("end of input did not produce an end result");

    // an item that leaves a sequence open produces no result
    a_no_mid_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && bytes_rem_next != '0) |-> !has_result)
        else $error("result produced inside a sequence");

endmodule

// ----- verif/utf8_byte_stream_decoder_top_tb.sv -----
// self-checking testbench for utf8_byte_stream_decoder_top: directed and random byte streams
// with random gaps and stalls on both stream ports; depends on u8dec_pkg and the decoder rtl
module utf8_byte_stream_decoder_top_tb;
    import u8dec_pkg::*;

    typedef struct packed {
        cp_t     cp;
        status_t st;
    } decoded_t;

    // tracks the decoder state and holds the code points still owed by the block
    class code_point_board;
        rem_t     bytes_left;
        cp_t      gathered;
        decoded_t due_points[$];
        int       fail_count;

        function new();
            bytes_left = '0;
            gathered   = '0;
            fail_count = 0;
        endfunction

        function void owe(cp_t cp, status_t st);
            decoded_t d;
            d.cp = cp;
            d.st = st;
            due_points.push_back(d);
        endfunction

        // note one accepted input item
        function void take_byte(logic [7:0] b, logic eoi);
            logic [5:0] payload;
            if (bytes_left == 0) begin
                if (eoi) begin
                    owe('0, ST_END);
                end else if (!b[7]) begin
                    owe(cp_t'(b), ST_OK);
                end else if (b[7:4] == 4'hf) begin
                    // leads 0xf8-0xff are taken as four-byte leads as well
                    gathered   = cp_t'(b[2:0]) << 18;
                    bytes_left = 2'd3;
                end else if (b[7:5] == 3'b111) begin
                    gathered   = cp_t'(b[3:0]) << 12;
                    bytes_left = 2'd2;
                end else if (b[7:6] == 2'b11) begin
                    gathered   = cp_t'(b[4:0]) << 6;
                    bytes_left = 2'd1;
                end else begin
                    owe('0, ST_INVALID);
                end
            end else begin
                // an end flag inside a sequence acts as payload of all ones
                payload    = eoi ? 6'h3f : b[5:0];
                gathered   = gathered | (cp_t'(payload) << (6 * (bytes_left - 1)));
                bytes_left = bytes_left - 2'd1;
                if (bytes_left == 0) begin
                    owe(gathered, ST_OK);
                    gathered = '0;
                end
            end
        endfunction

        // compare one accepted result item with the oldest owed one
        function void check_code_point(logic [23:0] tdata, logic [1:0] tuser);
            decoded_t d;
            if (due_points.size() == 0) begin
                $display("%0t: unexpected result, expected none, got code_point %h status %0d",
                         $time, tdata[CP_W-1:0], tuser);
                fail_count++;
                return;
            end
            d = due_points.pop_front();
            if (tdata[CP_W-1:0] !== d.cp) begin
                $display("%0t: code_point mismatch, expected %h, got %h",
                         $time, d.cp, tdata[CP_W-1:0]);
                fail_count++;
            end
            if (tuser !== d.st) begin
                $display("%0t: status mismatch, expected %0d, got %0d", $time, d.st, tuser);
                fail_count++;
            end
        endfunction

        function void report_leftover();
            while (due_points.size() != 0) begin
                $display("%0t: missing result, expected code_point %h status %0d, got none",
                         $time, due_points[0].cp, due_points[0].st);
                void'(due_points.pop_front());
                fail_count++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic [0:0]  s_axis_tuser = 1'b0;    // [0] end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [20:0] code_point, [23:21] zero
    logic [1:0]  m_axis_tuser;           // [1:0] status

    code_point_board board = new();
    int unsigned     bytes_sent = 0;
    bit              quiet = 1'b0;

    utf8_byte_stream_decoder_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("utf8_byte_stream_decoder_top test failed");
        $finish;
    end

    // mostly short gaps, a few long ones, none during quiet stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eoi);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= eoi;
        do @(posedge aclk); while (!s_axis_tready);
        board.take_byte(b, eoi);
        bytes_sent++;
    endtask

    // continuation bytes: mostly well formed, sometimes any byte or an end flag
    task automatic send_tail(input int unsigned count);
        int unsigned r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 5) send_byte(8'($urandom), 1'b1);
            else if (r < 17) send_byte(8'($urandom), 1'b0);
            else send_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
        end
    endtask

    task automatic send_random_char();
        int unsigned r;
        int unsigned cut;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            send_byte(8'($urandom_range(0, 127)), 1'b0);
        end else if (r < 55) begin
            send_byte(8'hc0 | 8'($urandom_range(0, 31)), 1'b0);
            send_tail(1);
        end else if (r < 70) begin
            send_byte(8'he0 | 8'($urandom_range(0, 15)), 1'b0);
            send_tail(2);
        end else if (r < 85) begin
            send_byte(8'hf0 | 8'($urandom_range(0, 15)), 1'b0);
            send_tail(3);
        end else if (r < 91) begin
            send_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
        end else if (r < 95) begin
            send_byte(8'($urandom), 1'b1);
        end else begin
            // broken sequence: any lead, zero to two tail bytes, then an arbitrary item
            cut = $urandom_range(0, 2);
            send_byte(8'hc0 | 8'($urandom_range(0, 63)), 1'b0);
            send_tail(cut);
            send_byte(8'($urandom), 1'($urandom_range(0, 3) == 0));
        end
    endtask

    // result side: random stalls, checked on every accepted result item
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready)
                board.check_code_point(m_axis_tdata, m_axis_tuser);
            if (stall_left != 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial begin
        int unsigned waited;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, each sequence length, odd leads, end flags
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hc0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hdf, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hef, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hf7, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hf8, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hbf, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'he3, 1'b0);
        send_byte(8'hc0, 1'b1);
        send_byte(8'h40, 1'b0);

        while (bytes_sent < 730) begin
            quiet = ((bytes_sent / 50) % 4) == 3;
            send_random_char();
        end
        quiet = 1'b0;
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (board.due_points.size() != 0 && waited < 10_000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (10) @(posedge aclk);
        board.report_leftover();

        if (board.fail_count == 0) begin
            $display("utf8_byte_stream_decoder_top test passed");
        end else begin
            $display("utf8_byte_stream_decoder_top test failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/u8dec_pkg.sv
sv/utf8_byte_stream_decoder_top.sv
verif/utf8_byte_stream_decoder_top_tb.sv
